### hdl/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and constants of the merge sorter: key width and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int KEY_W = 16;

  typedef struct packed {
    logic load;       // store the incoming key (or mark an overflow)
    logic run_setup;  // open the next pair of runs and prefetch both heads
    logic merge;      // move one key from a run head to the destination store
    logic next_run;   // step the run start to the next pair of runs
    logic next_pass;  // double the run width and restart at the first run
    logic flip;       // swap the roles of source and destination store
    logic out_next;   // step to the next sorted key
    logic clear;      // set done: back to an empty set
  } cmd_t;

  typedef struct packed {
    logic n_one;      // the set holds a single key
    logic k_last;     // the current merge step writes the last key of the run pair
    logic pass_last;  // the current run pair is the last one of the pass
    logic sort_last;  // the current pass is the last one
    logic out_last;   // the key on the output is the last one of the set
  } stat_t;

endpackage

### hdl/msort_ctrl.sv
// ----------------------------------------------------------------------------
// msort_ctrl
// Sequencer of the merge sorter: loading, merge passes and result delivery.
// ----------------------------------------------------------------------------
module msort_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tlast,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  msort_pkg::stat_t status,
  output msort_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_MERGE = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_SEND);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // A single key is already in order.
        if (status.n_one) begin
          state_next = ST_FETCH;
        end else begin
          cmd.run_setup = 1'b1;
          state_next    = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (status.k_last) begin
          if (status.pass_last) begin
            // The destination of this pass becomes the source of the next
            // one, or holds the sorted set for delivery.
            cmd.flip = 1'b1;
            if (status.sort_last) begin
              state_next = ST_FETCH;
            end else begin
              cmd.next_pass = 1'b1;
              state_next    = ST_SETUP;
            end
          end else begin
            cmd.next_run = 1'b1;
            state_next   = ST_SETUP;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (m_tready) begin
          if (status.out_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

### hdl/msort_dp.sv
// ----------------------------------------------------------------------------
// msort_dp
// Datapath of the merge sorter: key and scratch stores, run indices and the
// compare that picks the next key of a merge.
// ----------------------------------------------------------------------------
module msort_dp #(
  parameter int MAX_KEYS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msort_pkg::cmd_t               cmd,
  input  logic [msort_pkg::KEY_W-1:0]   s_tdata,
  output msort_pkg::stat_t              status,
  output logic [msort_pkg::KEY_W-1:0]   m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int EW = CW + 2;

  logic [msort_pkg::KEY_W-1:0] key_mem [MAX_KEYS];
  logic [msort_pkg::KEY_W-1:0] scr_mem [MAX_KEYS];
  logic [msort_pkg::KEY_W-1:0] key_rd_i, key_rd_j, scr_rd_i, scr_rd_j;

  logic [CW-1:0] count;
  logic          overflow;
  logic          src_scr;   // 1: the scratch store is the merge source
  logic [CW-1:0] run_start, run_width;
  logic [CW-1:0] out_idx;
  logic [CW-1:0] idx_i, idx_j, idx_k, mid, hi;

  logic [EW-1:0] mid_sum, hi_sum, width2, n_ext;
  logic [CW-1:0] mid_c, hi_c;
  logic          full;
  logic [msort_pkg::KEY_W-1:0] head_i, head_j, merge_data;
  logic          take_left;
  logic [CW-1:0] i_nx, j_nx, ra_i, ra_j;
  logic          key_we, scr_we;
  logic [AW-1:0] key_wa;
  logic [msort_pkg::KEY_W-1:0] key_wd;

  assign full    = (count == CW'(MAX_KEYS));
  assign n_ext   = EW'(count);
  assign width2  = EW'(run_width) << 1;
  assign mid_sum = EW'(run_start) + EW'(run_width);
  assign hi_sum  = EW'(run_start) + width2;
  assign mid_c   = (mid_sum > n_ext) ? count : mid_sum[CW-1:0];
  assign hi_c    = (hi_sum > n_ext) ? count : hi_sum[CW-1:0];

  assign head_i = src_scr ? scr_rd_i : key_rd_i;
  assign head_j = src_scr ? scr_rd_j : key_rd_j;

  // Ties go to the left run, which keeps the sort stable.
  always_comb begin
    take_left = (idx_i < mid) &&
                ((idx_j >= hi) || ($signed(head_i) <= $signed(head_j)));
  end

  assign merge_data = take_left ? head_i : head_j;
  assign i_nx = idx_i + CW'(take_left);
  assign j_nx = idx_j + CW'(!take_left);

  // Reads run ahead: the addresses follow the next indices so that
  // the run heads are ready in the register at the start of each step.
  assign ra_i = cmd.run_setup ? run_start : (cmd.merge ? i_nx : out_idx);
  assign ra_j = cmd.run_setup ? mid_c : j_nx;

  assign key_we = (cmd.load && !full) || (cmd.merge && src_scr);
  assign scr_we = cmd.merge && !src_scr;
  assign key_wa = cmd.load ? count[AW-1:0] : idx_k[AW-1:0];
  assign key_wd = cmd.load ? s_tdata : merge_data;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_i <= key_mem[ra_i[AW-1:0]];
    key_rd_j <= key_mem[ra_j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[idx_k[AW-1:0]] <= merge_data;
    end
    scr_rd_i <= scr_mem[ra_i[AW-1:0]];
    scr_rd_j <= scr_mem[ra_j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count     <= '0;
      overflow  <= 1'b0;
      src_scr   <= 1'b0;
      run_start <= '0;
      run_width <= CW'(1);
      out_idx   <= '0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.next_run) begin
        run_start <= hi_sum[CW-1:0];
      end
      if (cmd.next_pass) begin
        run_start <= '0;
        run_width <= width2[CW-1:0];
      end
      if (cmd.flip) begin
        src_scr <= !src_scr;
      end
      if (cmd.out_next) begin
        out_idx <= out_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_setup) begin
      idx_i <= run_start;
      idx_j <= mid_c;
      idx_k <= run_start;
      mid   <= mid_c;
      hi    <= hi_c;
    end else if (cmd.merge) begin
      idx_i <= i_nx;
      idx_j <= j_nx;
      idx_k <= idx_k + CW'(1);
    end
  end

  assign status.n_one     = (count == CW'(1));
  assign status.k_last    = ((idx_k + CW'(1)) == hi);
  assign status.pass_last = (hi_sum >= n_ext);
  assign status.sort_last = (width2 >= n_ext);
  assign status.out_last  = ((out_idx + CW'(1)) == count);

  assign m_tdata = head_i;
  assign m_tlast = status.out_last;
  assign m_tuser = overflow;

endmodule

### hdl/merge_sorter_core.sv
// ----------------------------------------------------------------------------
// merge_sorter_core
// Collects a set of signed keys, sorts them ascending by bottom-up merge
// passes between two stores and streams them out, the last one marked.
//
//   channel  dir  payload                                  end marker
//   s_*      in   tdata[15:0] key                          tlast: last key
//   m_*      out  tdata[15:0] sorted key, tuser[0] dropped tlast: end of set
//
// Loading takes one key per cycle. Sorting makes ceil(log2 n) merge passes,
// each run pair opening with a prefetch of both run heads from the source
// store; each result is then fetched on the store read port and offered.
// While a set is sorted or delivered s_tready stays low; a low m_tready
// holds the current result. Reset is synchronous and leaves an empty set.
// ----------------------------------------------------------------------------
module merge_sorter_core #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [msort_pkg::KEY_W-1:0] s_tdata,   // [15:0] key
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [msort_pkg::KEY_W-1:0] m_tdata,   // [15:0] sorted_key
  output logic                        m_tlast,
  output logic                        m_tuser    // [0] dropped
);

  msort_pkg::cmd_t  cmd;
  msort_pkg::stat_t status;

  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  msort_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

### dv/tb_merge_sorter_core.sv
// ----------------------------------------------------------------------------
// tb_merge_sorter_core
// Self-checking testbench for merge_sorter_core. Key sets are streamed in
// with random bursts and gaps while the result side stalls on shifting
// patterns. Every accepted key feeds a bottom-up merge sort model of the
// set, and each sorted result is compared field by field with the oldest
// prediction. Covers extreme and equal keys, single-key sets, a full store,
// an overflowing store and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_merge_sorter_core;

  localparam int STORE_DEPTH = 64;
  localparam int HOLD_CYCLES = 1000;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 50;

  typedef logic signed [msort_pkg::KEY_W-1:0] key_t;
  typedef key_t key_q_t[$];

  typedef struct {
    key_t key;
    logic eos;
    logic dropped;
  } sorted_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  key_t       s_tdata = '0;        // [15:0] key
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [msort_pkg::KEY_W-1:0] m_tdata;  // [15:0] sorted_key
  logic       m_tlast;
  logic       m_tuser;             // [0] dropped

  sorted_item_t sorted_due_q[$];
  key_q_t       pending_keys;
  logic         pending_overflow = 1'b0;

  int error_count     = 0;
  int keys_sent       = 0;
  int sets_sent       = 0;
  int results_checked = 0;
  int overflow_sets   = 0;
  int burst_left      = 0;
  int hold_requests   = 0;
  int idle_cycles     = 0;

  merge_sorter_core #(.MAX_KEYS(STORE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bottom-up merge passes; on equal keys the left run wins.
  function automatic key_q_t merge_sort_keys(key_q_t keys);
    key_q_t src;
    key_q_t dst;
    int n;
    int w;
    int lo;
    int mid;
    int hi;
    int i;
    int j;
    src = keys;
    n = src.size();
    for (w = 1; w < n; w = w * 2) begin
      dst = {};
      for (lo = 0; lo < n; lo = lo + 2 * w) begin
        mid = (lo + w < n) ? lo + w : n;
        hi = (lo + 2 * w < n) ? lo + 2 * w : n;
        i = lo;
        j = mid;
        while (i < mid || j < hi) begin
          if (j >= hi || (i < mid && src[i] <= src[j])) begin
            dst = {dst, src[i]};
            i++;
          end else begin
            dst = {dst, src[j]};
            j++;
          end
        end
      end
      src = dst;
    end
    return src;
  endfunction

  // Result checking, set prediction and the no-progress watchdog.
  always @(posedge clk) begin : monitor
    sorted_item_t due;
    key_q_t ordered;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (sorted_due_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, got key %0d last %b dropped %b",
                   $time, $signed(m_tdata), m_tlast, m_tuser);
        end else begin
          due = sorted_due_q.pop_front();
          if (m_tdata !== due.key) begin
            error_count++;
            $display("%0t: sorted_key mismatch: expected %0d, got %0d",
                     $time, due.key, $signed(m_tdata));
          end
          if (m_tlast !== due.eos) begin
            error_count++;
            $display("%0t: end_of_set mismatch: expected %b, got %b",
                     $time, due.eos, m_tlast);
          end
          if (m_tuser !== due.dropped) begin
            error_count++;
            $display("%0t: dropped mismatch: expected %b, got %b",
                     $time, due.dropped, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (pending_keys.size() < STORE_DEPTH)
          pending_keys = {pending_keys, s_tdata};
        else
          pending_overflow = 1'b1;
        if (s_tlast) begin
          ordered = merge_sort_keys(pending_keys);
          foreach (ordered[k]) begin
            due.key = ordered[k];
            due.eos = (k == ordered.size() - 1);
            due.dropped = pending_overflow;
            sorted_due_q = {sorted_due_q, due};
          end
          if (pending_overflow)
            overflow_sets++;
          pending_keys = {};
          pending_overflow = 1'b0;
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: rotating stall patterns, plus a long hold-off on request.
  always @(negedge clk) begin : result_sink
    static int pat_age = 0;
    static int hold_left = 0;
    static int hold_served = 0;
    static logic [15:0] stall_pat = 16'hFFFF;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (pat_age == 0) begin
      pat_age = 48;
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      if (stall_pat == '0)
        stall_pat = 16'h0001;
    end
    pat_age--;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= stall_pat[pat_age % 16];
    end
  end

  task automatic send_key(key_t key, logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata <= key_t'($urandom);
        s_tlast <= 1'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= key;
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
    keys_sent++;
  endtask

  task automatic send_set(key_q_t keys);
    foreach (keys[k])
      send_key(keys[k], k == keys.size() - 1);
    sets_sent++;
  endtask

  // Mix of extremes, a narrow band that makes duplicates, and full-range keys.
  function automatic key_t draw_key();
    case ($urandom_range(0, 9))
      0: return key_t'(16'h8000);
      1: return key_t'(16'h7FFF);
      2, 3: return key_t'($urandom_range(0, 7) - 4);
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic key_q_t draw_set(int n);
    key_q_t keys;
    repeat (n)
      keys = {keys, draw_key()};
    return keys;
  endfunction

  task automatic test_extreme_keys();
    send_set('{key_t'(16'h7FFF)});
    send_set('{key_t'(16'h8000)});
    send_set('{key_t'(16'h7FFF), key_t'(16'h8000), key_t'(0), key_t'(-1), key_t'(1)});
  endtask

  task automatic test_equal_and_ordered();
    send_set('{key_t'(5), key_t'(5), key_t'(5), key_t'(5)});
    send_set('{key_t'(-300), key_t'(-2), key_t'(0), key_t'(7), key_t'(7), key_t'(9000)});
    send_set('{key_t'(16'h7FFF), key_t'(1200), key_t'(3), key_t'(-3), key_t'(-1200),
               key_t'(16'h8000)});
  endtask

  // Three keys beyond the store, the last item among them: it still sorts.
  task automatic test_store_overflow();
    send_set(draw_set(STORE_DEPTH + 3));
  endtask

  // The result side holds off while the next set is offered, so the block
  // has to keep its input stalled until delivery resumes.
  task automatic test_output_backpressure();
    hold_requests++;
    send_set(draw_set(8));
    send_set(draw_set(8));
  endtask

  task automatic test_random_sets();
    int budget;
    int sent;
    int n;
    int full_at;
    bit full_done;
    budget = 124;
    sent = 0;
    full_at = $urandom_range(10, 60);
    full_done = 1'b0;
    while (sent < budget) begin
      if (!full_done && sent >= full_at) begin
        n = STORE_DEPTH;
        full_done = 1'b1;
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24)
                                         : $urandom_range(1, 12);
      end
      send_set(draw_set(n));
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extreme_keys();
    test_equal_and_ordered();
    test_store_overflow();
    test_output_backpressure();
    test_random_sets();

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (sorted_due_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d keys in %0d sets (%0d with dropped keys); checked %0d results.",
             keys_sent, sets_sent, overflow_sets, results_checked);
    $display("Included single-key sets, extreme and equal keys, a full store,");
    $display("an overflow and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (error_count == 0 && sorted_due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
